[src/stg_pkg.sv]
package stg_pkg;

    localparam int MAX_DIMS_DEF = 4;
    localparam int LANE_W       = 16;
    localparam int IDX_W        = 32;
    localparam int OFF_W        = 36;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_BASE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DST_BASE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EXTENTS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_PITCH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DST_PITCH  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTIG     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ELEM_BYTES = 3'd7;

    // One request in flight through the pipeline.
    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   quo;
        logic [LANE_W-1:0]  rem;
        logic [OFF_W-1:0]   soff;
        logic [OFF_W-1:0]   doff;
        logic [31:0]        sprod;
        logic [31:0]        dprod;
    } stg_item_t;

    typedef struct packed {
        logic [2:0]         num_dims;
        logic [31:0]        src_base;
        logic [31:0]        dst_base;
        logic [63:0]        extents;
        logic [63:0]        src_pitch;
        logic [63:0]        dst_pitch;
        logic               contig;
        logic [4:0]         elem_bytes;
    } stg_cfg_t;

endpackage

[src/strided_tensor_address_gen.sv]
// Strided tensor address generator. Each request on s_axis carries a linear
// element index; the block returns one pair of byte offsets (source, destination)
// on m_axis. The index is split into mixed-radix coordinates, innermost
// dimension (num_dims-1) first, by a pipelined restoring divider that resolves
// one quotient bit per stage, 32 stages per dimension, followed by a multiply
// stage and an accumulate stage. One request is accepted every cycle, but the
// whole pipeline stalls while a result waits at the output and m_axis_tready is
// low. Configuration is written through cfg_we/cfg_addr/cfg_wdata, by the user
// only while no requests are in flight; the block itself does not enforce this.
module strided_tensor_address_gen
    import stg_pkg::*;
#(
    parameter int MAX_DIMS = MAX_DIMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [31:0] element_index
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata    // [35:0] src_byte_offset,
                                                  // [71:36] dst_byte_offset
);

    stg_cfg_t           cfg;
    stg_item_t          in_reg;
    stg_item_t          chain [0:MAX_DIMS];
    logic               out_vld_reg;
    logic [OFF_W-1:0]   out_src_reg;
    logic [OFF_W-1:0]   out_dst_reg;
    logic               adv;
    logic [2:0]         dims_eff;
    logic [IDX_W+4:0]   contig_prod;

    stg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        if (cfg.num_dims == 3'd0)
            dims_eff = 3'd1;
        else if (cfg.num_dims > 3'(MAX_DIMS))
            dims_eff = 3'(MAX_DIMS);
        else
            dims_eff = cfg.num_dims;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_reg <= '0;
        else if (adv)
        begin
            in_reg.vld   <= s_axis_tvalid;
            in_reg.idx   <= s_axis_tdata;
            in_reg.quo   <= s_axis_tdata;
            in_reg.rem   <= '0;
            in_reg.soff  <= OFF_W'(cfg.src_base);
            in_reg.doff  <= OFF_W'(cfg.dst_base);
            in_reg.sprod <= '0;
            in_reg.dprod <= '0;
        end
    end

    assign chain[0] = in_reg;

    // Dimensions run from the innermost down to 0. Dimensions not in use, and
    // zero extents, divide by one, which leaves a coordinate of zero.
    genvar g;
    generate
        for (g = 0; g < MAX_DIMS; g++)
        begin : g_dim
            localparam int D = MAX_DIMS - 1 - g;
            logic [LANE_W-1:0] lane_ext;
            logic [LANE_W-1:0] ext_eff;

            assign lane_ext = cfg.extents[D*LANE_W +: LANE_W];
            assign ext_eff  = (3'(D) >= dims_eff || lane_ext == '0) ?
                              LANE_W'(1) : lane_ext;

            stg_dim_unit u_dim (
                .clk        (clk),
                .rst_n      (rst_n),
                .adv        (adv),
                .ext        (ext_eff),
                .src_stride (cfg.src_pitch[D*LANE_W +: LANE_W]),
                .dst_stride (cfg.dst_pitch[D*LANE_W +: LANE_W]),
                .in_item    (chain[g]),
                .out_item   (chain[g+1])
            );
        end
    endgenerate

    assign contig_prod = (IDX_W+5)'(chain[MAX_DIMS].idx) * (IDX_W+5)'(cfg.elem_bytes);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= chain[MAX_DIMS].vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_src_reg <= chain[MAX_DIMS].soff;
            out_dst_reg <= cfg.contig ? contig_prod[OFF_W-1:0] : chain[MAX_DIMS].doff;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_dst_reg, out_src_reg};

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> in_reg.vld)
        else $error("accepted request did not enter the pipeline");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(in_reg) && $stable(chain[MAX_DIMS].vld))
        else $error("pipeline moved during a stall");

    a_feed_out : assert property (@(posedge clk) disable iff (!rst_n)
        adv && chain[MAX_DIMS].vld |=> m_axis_tvalid)
        else $error("finished request lost before the output");

endmodule

[src/stg_cfg.sv]
module stg_cfg
    import stg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output stg_cfg_t              cfg
);

    stg_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_dims   <= 3'd1;
            cfg_reg.src_base   <= '0;
            cfg_reg.dst_base   <= '0;
            cfg_reg.extents    <= 64'h0001_0001_0001_0001;
            cfg_reg.src_pitch  <= '0;
            cfg_reg.dst_pitch  <= '0;
            cfg_reg.contig     <= 1'b0;
            cfg_reg.elem_bytes <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NUM_DIMS:   cfg_reg.num_dims   <= cfg_wdata[2:0];
                REG_SRC_BASE:   cfg_reg.src_base   <= cfg_wdata[31:0];
                REG_DST_BASE:   cfg_reg.dst_base   <= cfg_wdata[31:0];
                REG_EXTENTS:    cfg_reg.extents    <= cfg_wdata;
                REG_SRC_PITCH:  cfg_reg.src_pitch  <= cfg_wdata;
                REG_DST_PITCH:  cfg_reg.dst_pitch  <= cfg_wdata;
                REG_CONTIG:     cfg_reg.contig     <= cfg_wdata[0];
                REG_ELEM_BYTES: cfg_reg.elem_bytes <= cfg_wdata[4:0];
                default:        cfg_reg.num_dims   <= cfg_reg.num_dims;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/stg_div_step.sv]
module stg_div_step
    import stg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [LANE_W-1:0] ext,
    input  stg_item_t         in_item,
    output stg_item_t         out_item
);

    stg_item_t        item_reg;
    stg_item_t        item_next;
    logic [LANE_W:0]  trial;
    logic             fits;

    // One restoring division step: one quotient bit per stage.
    always_comb
    begin
        item_next = in_item;
        trial     = {in_item.rem, in_item.quo[IDX_W-1]};
        fits      = (trial >= {1'b0, ext});
        item_next.rem = fits ? LANE_W'(trial - {1'b0, ext}) : trial[LANE_W-1:0];
        item_next.quo = {in_item.quo[IDX_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else if (adv)
            item_reg <= item_next;
    end

    assign out_item = item_reg;

endmodule

[src/stg_dim_unit.sv]
module stg_dim_unit
    import stg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [LANE_W-1:0] ext,
    input  logic [LANE_W-1:0] src_stride,
    input  logic [LANE_W-1:0] dst_stride,
    input  stg_item_t         in_item,
    output stg_item_t         out_item
);

    stg_item_t chain [0:IDX_W];
    stg_item_t mul_reg;
    stg_item_t add_reg;

    assign chain[0] = in_item;

    genvar g;
    generate
        for (g = 0; g < IDX_W; g++)
        begin : g_div
            stg_div_step u_step (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .ext      (ext),
                .in_item  (chain[g]),
                .out_item (chain[g+1])
            );
        end
    endgenerate

    // Remainder is the coordinate; quotient carries on to the next dimension.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg <= '0;
            add_reg <= '0;
        end
        else if (adv)
        begin
            mul_reg.vld   <= chain[IDX_W].vld;
            mul_reg.idx   <= chain[IDX_W].idx;
            mul_reg.quo   <= chain[IDX_W].quo;
            mul_reg.rem   <= chain[IDX_W].rem;
            mul_reg.soff  <= chain[IDX_W].soff;
            mul_reg.doff  <= chain[IDX_W].doff;
            mul_reg.sprod <= 32'(chain[IDX_W].rem) * 32'(src_stride);
            mul_reg.dprod <= 32'(chain[IDX_W].rem) * 32'(dst_stride);

            add_reg.vld   <= mul_reg.vld;
            add_reg.idx   <= mul_reg.idx;
            add_reg.quo   <= mul_reg.quo;
            add_reg.rem   <= '0;
            add_reg.soff  <= mul_reg.soff + OFF_W'(mul_reg.sprod);
            add_reg.doff  <= mul_reg.doff + OFF_W'(mul_reg.dprod);
            add_reg.sprod <= '0;
            add_reg.dprod <= '0;
        end
    end

    assign out_item = add_reg;

endmodule

[bench/testbench.sv]
module testbench;
    import stg_pkg::*;

    localparam int LATENCY = MAX_DIMS_DEF * 34 + 2;

    typedef struct packed {
        logic [OFF_W-1:0] dst_off;
        logic [OFF_W-1:0] src_off;
    } offset_pair_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // [31:0] element_index
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [71:0]           m_axis_tdata;   // [35:0] src_byte_offset, [71:36] dst_byte_offset

    // Shadow copy of the configuration registers.
    logic [2:0]  sh_dims;
    logic [31:0] sh_src_base;
    logic [31:0] sh_dst_base;
    logic [63:0] sh_extents;
    logic [63:0] sh_src_pitch;
    logic [63:0] sh_dst_pitch;
    logic        sh_contig;
    logic [4:0]  sh_elem_bytes;

    offset_pair_t pending_offsets[$];
    int unsigned  mismatches;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;

    strided_tensor_address_gen dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic offset_pair_t compute_offsets(logic [31:0] idx);
        offset_pair_t res;
        logic [63:0]  rest;
        logic [63:0]  ext;
        logic [63:0]  coord;
        logic [63:0]  soff;
        logic [63:0]  doff;
        int           dims;
        dims = int'(sh_dims);
        if (dims < 1)
            dims = 1;
        if (dims > MAX_DIMS_DEF)
            dims = MAX_DIMS_DEF;
        rest = 64'(idx);
        soff = 64'(sh_src_base);
        doff = 64'(sh_dst_base);
        for (int d = dims - 1; d >= 0; d--)
        begin
            ext = 64'(sh_extents[d*16 +: 16]);
            if (ext == 64'd0)
                ext = 64'd1;
            coord = rest % ext;
            rest  = rest / ext;
            soff += coord * 64'(sh_src_pitch[d*16 +: 16]);
            doff += coord * 64'(sh_dst_pitch[d*16 +: 16]);
        end
        if (sh_contig)
            doff = 64'(idx) * 64'(sh_elem_bytes);
        res.src_off = soff[OFF_W-1:0];
        res.dst_off = doff[OFF_W-1:0];
        return res;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            REG_NUM_DIMS:   sh_dims       = value[2:0];
            REG_SRC_BASE:   sh_src_base   = value[31:0];
            REG_DST_BASE:   sh_dst_base   = value[31:0];
            REG_EXTENTS:    sh_extents    = value;
            REG_SRC_PITCH:  sh_src_pitch  = value;
            REG_DST_PITCH:  sh_dst_pitch  = value;
            REG_CONTIG:     sh_contig     = value[0];
            REG_ELEM_BYTES: sh_elem_bytes = value[4:0];
            default:        ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_offsets.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic load_geometry(logic [2:0] dims, logic [63:0] ext, logic [63:0] ss,
                                 logic [63:0] ds, logic [31:0] sb, logic [31:0] db,
                                 logic contig, logic [4:0] eb);
        wait_drained();
        write_reg(REG_NUM_DIMS, 64'(dims));
        write_reg(REG_EXTENTS, ext);
        write_reg(REG_SRC_PITCH, ss);
        write_reg(REG_DST_PITCH, ds);
        write_reg(REG_SRC_BASE, 64'(sb));
        write_reg(REG_DST_BASE, 64'(db));
        write_reg(REG_CONTIG, 64'(contig));
        write_reg(REG_ELEM_BYTES, 64'(eb));
    endtask

    // Called just after a rising edge; leaves tvalid high when the request is taken.
    task automatic send_index(logic [31:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= idx;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_offsets.push_back(compute_offsets(idx));
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        offset_pair_t want;
        offset_pair_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_offsets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result src=%h dst=%h", got.src_off, got.dst_off);
            end
            else
            begin
                want = pending_offsets.pop_front();
                if (got.src_off !== want.src_off || got.dst_off !== want.dst_off)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("offset mismatch: src exp %h got %h, dst exp %h got %h",
                                 want.src_off, got.src_off, want.dst_off, got.dst_off);
                end
            end
        end
    end

    function automatic logic [31:0] rand_index();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(255);
            2:       return $urandom_range(65535);
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    function automatic logic [63:0] rand_lanes(int mode);
        logic [63:0] w;
        for (int d = 0; d < 4; d++)
        begin
            case (mode == 0 ? $urandom_range(4) : mode)
                0:       w[d*16 +: 16] = 16'h0;
                1:       w[d*16 +: 16] = 16'hFFFF;
                2:       w[d*16 +: 16] = 16'($urandom_range(1, 12));
                default: w[d*16 +: 16] = 16'($urandom);
            endcase
        end
        return w;
    endfunction

    task automatic test_reset_defaults();
        send_index(32'h0);
        send_index(32'hFFFF_FFFF);
        stop_sending();
    endtask

    task automatic test_directed_extremes();
        logic [31:0] picks [10] = '{32'h0, 32'h1, 32'h4, 32'h5, 32'hFFFF_FFFF,
                                    32'h8000_0000, 32'h0004_FFFA, 32'h0005_0000,
                                    32'hAAAA_5555, 32'h5555_AAAA};
        load_geometry(3'd4, 64'h0003_0000_FFFF_0005, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'h0001_0002_0004_0008, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd1);
        foreach (picks[i])
            send_index(picks[i]);
        stop_sending();
        // Dimension count zero and above the maximum; contiguous with odd element sizes.
        load_geometry(3'd0, 64'hFFFF_FFFF_FFFF_0007, 64'h0000_0000_0000_FFFF,
                      64'h0, 32'h0, 32'h0, 1'b1, 5'd31);
        send_index(32'hFFFF_FFFF);
        send_index(32'd20);
        stop_sending();
        load_geometry(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678, 32'h0, 1'b1, 5'd0);
        send_index(32'hFFFF_FFFF);
        send_index(32'h0001_0002);
        stop_sending();
        load_geometry(3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd16);
        send_index(32'hFFFE_FFFE);
        send_index(32'hFFFF_FFFF);
        stop_sending();
        // Single register writes on their own, with the block idle before them.
        wait_drained();
        write_reg(REG_ELEM_BYTES, 64'd16);
        write_reg(REG_CONTIG, 64'd1);
        send_index(32'hFFFF_FFFF);
        stop_sending();
    endtask

    task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
            begin
                stop_sending();
                load_geometry(3'($urandom_range(7)), rand_lanes($urandom_range(1) ? 2 : 0),
                              rand_lanes(0), rand_lanes(0), $urandom, $urandom,
                              1'($urandom), 5'($urandom));
            end
            send_index(rand_index());
        end
        stop_sending();
    endtask

    initial
    begin
        cfg_we         = 1'b0;
        cfg_addr       = REG_NUM_DIMS;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        sh_dims        = 3'd1;
        sh_src_base    = '0;
        sh_dst_base    = '0;
        sh_extents     = 64'h0001_0001_0001_0001;
        sh_src_pitch   = '0;
        sh_dst_pitch   = '0;
        sh_contig      = 1'b0;
        sh_elem_bytes  = 5'd1;
        rst_n          = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_random_phase(0, 0, 400);
        test_random_phase(62, 0, 380);
        test_random_phase(0, 62, 380);
        test_random_phase(35, 35, 380);
        test_random_phase(0, 0, 40);

        wait_drained();
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

[sim.f]
src/stg_pkg.sv
src/stg_cfg.sv
src/stg_div_step.sv
src/stg_dim_unit.sv
src/strided_tensor_address_gen.sv
bench/testbench.sv
